// File: rtl/core/lpl_pkg.sv
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types, widths and constants of the lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 20;
    localparam int CEIL_W     = 24;
    localparam int COEF_W     = 24;
    localparam int DELAY_W    = 8;
    localparam int ENV_W      = 25;
    localparam int SCALED_W   = 28;
    localparam int QUO_W      = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W    = 29;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd4;

    // register reset values
    localparam logic               ENABLE_RST  = 1'b1;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 20'd65536;
    localparam logic [CEIL_W-1:0]  CEILING_RST = 24'd8103815;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 24'd16768441;
    localparam logic [DELAY_W-1:0] DELAY_RST   = 8'd10;

    // unity gain in Q1.24
    localparam logic [ENV_W-1:0]   UNITY_Q24   = 25'd16777216;

    localparam int DELAY_DEPTH_DEF = 256;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic        [ENV_W-1:0]    gain_now;
    } out_item_t;

    // one entry of the delay ring, both channels
    typedef struct packed {
        logic signed [SCALED_W-1:0] left;
        logic signed [SCALED_W-1:0] right;
    } dly_pair_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/core/lpl_mul.sv
// ----------------------------------------------------------------------------
// lpl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lpl_mul
    import lpl_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  product
);

    logic signed [PROD_W-1:0] product_reg;

    // one product per cycle, operands chosen by the sequencer
    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// File: rtl/core/lpl_div.sv
// ----------------------------------------------------------------------------
// lpl_div
// Restoring serial divider: ceiling * 2^24 / peak, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lpl_div
    import lpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CEIL_W-1:0]   dividend,
    input  logic [SCALED_W-1:0] divisor,
    output logic [QUO_W-1:0]    quotient,
    output div_stat_t           stat
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SCALED_W-1:0] rem_reg, rem_next;
    logic [SCALED_W-1:0] dvs_reg, dvs_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;

    logic [SCALED_W:0]   trial;
    logic [SCALED_W:0]   diff;
    logic                fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, 1'b0};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(QUO_W);
            rem_next   = SCALED_W'(dividend);
            dvs_next   = divisor;
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[SCALED_W-1:0] : trial[SCALED_W-1:0];
            quo_next   = {quo_reg[QUO_W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/lpl_dly_mem.sv
// ----------------------------------------------------------------------------
// lpl_dly_mem
// Stereo delay ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpl_dly_mem
    import lpl_pkg::*;
#(
    parameter  int DEPTH  = DELAY_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  dly_pair_t         wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output dly_pair_t         rd_data
);

    dly_pair_t mem [DEPTH];
    dly_pair_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lookahead_peak_limiter_unit.sv
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_unit
// Stereo lookahead brickwall peak limiter, one Q1.23 sample pair per item.
// ----------------------------------------------------------------------------
// An enabled item runs from acceptance to the load of its result into a free
// output register through input gain, the ring write, the gain target (from
// the 24-step serial divider when the peak is over the ceiling, else unity),
// the envelope update and output scaling, on the single shared multiplier
// (two input gain products, two release products unless attacking, two
// output products). A bypassed item (enable 0) goes straight to output.
// in_ready is high only while the sequencer is idle, from the cycle after a
// result is loaded; a finished result waits in the output register, so the
// next item can be accepted before it is taken. The delay ring needs no
// clearing pass after reset: a wrap flag marks unwritten entries, which read
// as zero. Configuration writes are taken in every cycle.
module lookahead_peak_limiter_unit
    import lpl_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int DW = (AW > DELAY_W) ? AW : DELAY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_CAP_R,
        S_WRITE,
        S_DIV,
        S_ENV_A,
        S_ENV_B,
        S_ENV_C,
        S_OUT_L,
        S_OUT_R,
        S_CAP_O,
        S_OUT
    } state_t;

    // configuration registers
    logic               enable_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [CEIL_W-1:0]  ceil_reg;
    logic [COEF_W-1:0]  release_reg;
    logic [DELAY_W-1:0] delay_reg;

    // control state
    state_t             state_reg, state_next;
    logic [ENV_W-1:0]   env_reg, env_next;
    logic [AW-1:0]      wpos_reg, wpos_next;
    logic               wrapped_reg, wrapped_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               bypass_reg, bypass_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    // payload registers
    logic signed [SAMPLE_W-1:0] lin_reg, lin_next;
    logic signed [SAMPLE_W-1:0] rin_reg, rin_next;
    logic signed [SCALED_W-1:0] sl_reg, sl_next;
    logic signed [SCALED_W-1:0] sr_reg, sr_next;
    logic [ENV_W-1:0]           target_reg, target_next;
    logic [2*COEF_W:0]          acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] oleft_reg, oleft_next;
    logic signed [SAMPLE_W-1:0] oright_reg, oright_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [PROD_W-1:0]   rnd_gain;
    logic signed [PROD_W-1:0]   rnd_out;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SAMPLE_W-1:0] limited;
    logic [2*COEF_W+1:0]        env_sum;
    logic [ENV_W-1:0]           rel_comp;

    // divider
    logic                       div_start;
    logic [QUO_W-1:0]           div_quotient;
    div_stat_t                  div_stat;

    // delay ring access
    logic [SCALED_W-1:0]        mag_l;
    logic [SCALED_W-1:0]        mag_r;
    logic [SCALED_W-1:0]        peak;
    logic                       over_ceil;
    logic [DW-1:0]              dly_ext;
    logic [DW-1:0]              dly_clamp;
    logic [AW-1:0]              delay_eff;
    logic [AW:0]                rd_wrap;
    logic [AW-1:0]              rd_addr;
    logic                       mem_en;
    dly_pair_t                  wr_pair;
    dly_pair_t                  rd_pair;
    logic signed [SCALED_W-1:0] dl;
    logic signed [SCALED_W-1:0] dr;

    function automatic logic signed [SAMPLE_W-1:0] sat_out(
        input logic signed [PROD_W-SAMPLE_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] res;
        if (v > (PROD_W-SAMPLE_W)'(signed'(25'sd8388607)))
        begin
            res = 24'sd8388607;
        end
        else if (v < (PROD_W-SAMPLE_W)'(signed'(25'sh1800000)))
        begin
            res = -24'sd8388608;
        end
        else
        begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= ENABLE_RST;
            gain_reg    <= GAIN_RST;
            ceil_reg    <= CEILING_RST;
            release_reg <= RELEASE_RST;
            delay_reg   <= DELAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                REG_GAIN:    gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_CEILING: ceil_reg    <= cfg_data[CEIL_W-1:0];
                REG_RELEASE: release_reg <= cfg_data[COEF_W-1:0];
                REG_DELAY:   delay_reg   <= cfg_data[DELAY_W-1:0];
                default:     ;
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MUL_L:
            begin
                mul_a = MUL_A_W'(lin_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            S_MUL_R:
            begin
                mul_a = MUL_A_W'(rin_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            S_ENV_A:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = MUL_B_W'(release_reg);
            end
            S_ENV_B:
            begin
                mul_a = MUL_A_W'(target_reg);
                mul_b = MUL_B_W'(rel_comp);
            end
            S_OUT_L:
            begin
                mul_a = MUL_A_W'(dl);
                mul_b = MUL_B_W'(env_reg);
            end
            S_OUT_R:
            begin
                mul_a = MUL_A_W'(dr);
                mul_b = MUL_B_W'(env_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lpl_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // rounding of products
    always_comb
    begin
        rel_comp = UNITY_Q24 - ENV_W'(release_reg);
        rnd_gain = product + PROD_W'(32768);
        scaled   = rnd_gain[SCALED_W+15:16];
        rnd_out  = product + PROD_W'(8388608);
        limited  = sat_out(rnd_out[PROD_W-1:SAMPLE_W]);
        env_sum  = (2*COEF_W+2)'(acc_reg) + (2*COEF_W+2)'(product[2*COEF_W:0])
                 + (2*COEF_W+2)'(8388608);
    end

    // stereo peak and ring addressing
    always_comb
    begin
        mag_l     = sl_reg[SCALED_W-1] ? SCALED_W'(-sl_reg) : SCALED_W'(sl_reg);
        mag_r     = sr_reg[SCALED_W-1] ? SCALED_W'(-sr_reg) : SCALED_W'(sr_reg);
        peak      = (mag_l > mag_r) ? mag_l : mag_r;
        over_ceil = (peak > SCALED_W'(ceil_reg));
        dly_ext   = DW'(delay_reg);
        if (dly_ext == '0)
        begin
            dly_clamp = DW'(1);
        end
        else if (dly_ext > DW'(DELAY_DEPTH - 1))
        begin
            dly_clamp = DW'(DELAY_DEPTH - 1);
        end
        else
        begin
            dly_clamp = dly_ext;
        end
        delay_eff = dly_clamp[AW-1:0];
        rd_wrap   = {1'b0, wpos_reg} + (AW+1)'(DELAY_DEPTH) - {1'b0, delay_eff};
        rd_addr   = (wpos_reg >= delay_eff) ? (wpos_reg - delay_eff) : rd_wrap[AW-1:0];
        wr_pair.left  = sl_reg;
        wr_pair.right = sr_reg;
        dl = rd_ok_reg ? rd_pair.left  : '0;
        dr = rd_ok_reg ? rd_pair.right : '0;
    end

    assign mem_en    = (state_reg == S_WRITE);
    assign div_start = mem_en && over_ceil;

    lpl_dly_mem #(
        .DEPTH (DELAY_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_en),
        .wr_addr (wpos_reg),
        .wr_data (wr_pair),
        .rd_en   (mem_en),
        .rd_addr (rd_addr),
        .rd_data (rd_pair)
    );

    lpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ceil_reg),
        .divisor  (peak),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        env_next       = env_reg;
        wpos_next      = wpos_reg;
        wrapped_next   = wrapped_reg;
        rd_ok_next     = rd_ok_reg;
        bypass_next    = bypass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        lin_next       = lin_reg;
        rin_next       = rin_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        oleft_next     = oleft_reg;
        oright_next    = oright_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lin_next    = in_item.in_left;
                    rin_next    = in_item.in_right;
                    bypass_next = !enable_reg;
                    state_next  = enable_reg ? S_MUL_L : S_OUT;
                end
            end
            S_MUL_L:
            begin
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                sl_next    = scaled;
                state_next = S_CAP_R;
            end
            S_CAP_R:
            begin
                sr_next    = scaled;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // write the new pair, fetch the delayed one, advance the ring
                rd_ok_next   = wrapped_reg || (wpos_reg >= delay_eff);
                wrapped_next = wrapped_reg || (wpos_reg == AW'(DELAY_DEPTH - 1));
                wpos_next    = (wpos_reg == AW'(DELAY_DEPTH - 1)) ? '0
                             : wpos_reg + AW'(1);
                if (over_ceil)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    target_next = UNITY_Q24;
                    state_next  = S_ENV_A;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    target_next = ENV_W'(div_quotient);
                    state_next  = S_ENV_A;
                end
            end
            S_ENV_A:
            begin
                // instant attack, else one-pole release
                if (target_reg < env_reg)
                begin
                    env_next   = target_reg;
                    state_next = S_OUT_L;
                end
                else
                begin
                    state_next = S_ENV_B;
                end
            end
            S_ENV_B:
            begin
                acc_next   = product[2*COEF_W:0];
                state_next = S_ENV_C;
            end
            S_ENV_C:
            begin
                env_next   = env_sum[2*COEF_W:COEF_W];
                state_next = S_OUT_L;
            end
            S_OUT_L:
            begin
                state_next = S_OUT_R;
            end
            S_OUT_R:
            begin
                oleft_next = limited;
                state_next = S_CAP_O;
            end
            S_CAP_O:
            begin
                oright_next = limited;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // hand the item to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (bypass_reg)
                    begin
                        out_item_next.out_left  = lin_reg;
                        out_item_next.out_right = rin_reg;
                        out_item_next.gain_now  = UNITY_Q24;
                    end
                    else
                    begin
                        out_item_next.out_left  = oleft_reg;
                        out_item_next.out_right = oright_reg;
                        out_item_next.gain_now  = env_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_reg       <= UNITY_Q24;
            wpos_reg      <= '0;
            wrapped_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            wpos_reg      <= wpos_next;
            wrapped_reg   <= wrapped_next;
            rd_ok_reg     <= rd_ok_next;
            bypass_reg    <= bypass_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        lin_reg    <= lin_next;
        rin_reg    <= rin_next;
        sl_reg     <= sl_next;
        sr_reg     <= sr_next;
        target_reg <= target_next;
        acc_reg    <= acc_next;
        oleft_reg  <= oleft_next;
        oright_reg <= oright_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // envelope never rises above unity gain
    a_env_unity: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= UNITY_Q24)
        else $error("envelope above unity");

    // ring write position stays inside the ring
    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= AW'(DELAY_DEPTH - 1))
        else $error("write position out of range");

    // divider is never restarted mid-division
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a division result only arrives while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result outside wait state");

    // an accepted enabled item leaves the idle state
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && enable_reg) |=> (state_reg == S_MUL_L))
        else $error("accepted item not started");

endmodule
